>>> sv/pcc_pkg.sv
// shared constants, types and the sine table for the phase chain coupling block
`default_nettype none

package pcc_pkg;

   localparam int PHASE_BITS      = 16;
   localparam int SINE_TABLE_BITS = 10;

   localparam int TAB_QBITS = SINE_TABLE_BITS - 2;
   localparam int QUARTER   = 1 << TAB_QBITS;

   localparam int PHASE_W   = 16;
   localparam int GAMMA_W   = 15;
   localparam int RATE_W    = 16;
   localparam int TRIG_W    = 14;
   localparam int QSINE_W   = 13;
   localparam int PROD_W    = GAMMA_W + TRIG_W;
   localparam int G_W       = PROD_W - 12;
   localparam int WIDE_W    = 19;
   localparam int FRAC_BITS = 12;

   localparam longint unsigned PI_Q30     = 64'd3373259426;
   localparam longint unsigned QUARTER_X2 = 2 * QUARTER;
   localparam longint unsigned TAYLOR_DIV [1:9] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

   localparam logic [GAMMA_W-1:0]        GAMMA_RESET = 15'd4915;
   localparam logic signed [TRIG_W:0]    ONE_Q12     = 15'sd4096;
   localparam logic [PROD_W-1:0]         HALF_Q12    = PROD_W'(2048);
   localparam logic signed [WIDE_W-1:0]  RATE_MAX    = 19'sd32767;
   localparam logic signed [WIDE_W-1:0]  RATE_MIN    = -19'sd32768;

   // what an item does at the end of the pipe
   localparam logic [1:0] KIND_FIRST = 2'd0;  // opens a chain, no result
   localparam logic [1:0] KIND_LONE  = 2'd1;  // single element chain
   localparam logic [1:0] KIND_MID   = 2'd2;  // interior element
   localparam logic [1:0] KIND_END   = 2'd3;  // closes a chain, two results

   typedef logic [PHASE_BITS-1:0]      phase_type;
   typedef logic [SINE_TABLE_BITS-1:0] tab_idx_type;
   typedef logic signed [TRIG_W-1:0]   trig_type;
   typedef logic signed [RATE_W-1:0]   rate_type;
   typedef logic [GAMMA_W-1:0]         gamma_type;
   typedef logic [G_W-1:0]             gterm_type;
   typedef logic [1:0]                 kind_type;
   typedef logic [QSINE_W-1:0]         qtab_type [0:QUARTER];

   typedef struct packed {
      logic load1;
      logic load2;
   } pipe_ctl_type;

   // first quadrant sine, q30 taylor series rounded to q1.12
   function automatic logic [QSINE_W-1:0] quadrant_sine(int unsigned q);
      longint unsigned x;
      longint unsigned term;
      longint unsigned rnd;
      longint          sum;
      int              n;
      x    = (PI_Q30 * 64'(q)) / QUARTER_X2;
      sum  = longint'(x);
      term = x;
      for (n = 1; n <= 9; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / TAYLOR_DIV[n];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rnd = (longint'(unsigned'(sum)) + 64'd131072) >> 18;
      return QSINE_W'(rnd);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int k = 0; k <= QUARTER; k++) begin
         t[k] = quadrant_sine(k);
      end
      return t;
   endfunction

   localparam qtab_type QSINE = build_qtab();

   // top table-index bits of a phase difference, shifted up when the phase is narrow
   function automatic tab_idx_type table_index(phase_type d);
      logic [PHASE_BITS+SINE_TABLE_BITS-1:0] w;
      w = {d, {SINE_TABLE_BITS{1'b0}}};
      return w[PHASE_BITS+SINE_TABLE_BITS-1 -: SINE_TABLE_BITS];
   endfunction

   // full-turn sine from the quarter table by symmetry
   function automatic trig_type sine_lookup(tab_idx_type idx);
      logic [1:0]           quad;
      logic [TAB_QBITS-1:0] q;
      logic [TAB_QBITS:0]   addr;
      trig_type             v;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      q    = idx[TAB_QBITS-1:0];
      addr = quad[0] ? ((TAB_QBITS+1)'(QUARTER) - {1'b0, q}) : {1'b0, q};
      v    = signed'({1'b0, QSINE[addr]});
      return quad[1] ? -v : v;
   endfunction

   function automatic rate_type sat_rate(logic signed [WIDE_W-1:0] v);
      if (v > RATE_MAX) begin
         return RATE_MAX[RATE_W-1:0];
      end else if (v < RATE_MIN) begin
         return RATE_MIN[RATE_W-1:0];
      end
      return v[RATE_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/pcc_front.sv
// input register: chain tracking and wrapped phase differences
`default_nettype none

module pcc_front
   import pcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire phase_type  in_phase,
   input  wire logic       in_last,
   output logic            in_ready,
   input  wire logic       take,
   output logic            valid,
   output phase_type       d_right,
   output phase_type       d_left,
   output kind_type        kind
);

   logic      valid_ff, valid_in;
   logic      started_ff, started_in;
   phase_type held_ff, held_in;
   phase_type dr_ff, dl_ff;
   kind_type  kind_ff, kind_in;
   logic      accept;

   assign in_ready = !valid_ff || take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      started_in = started_ff;
      held_in    = held_ff;
      kind_in    = kind_ff;
      valid_in   = accept ? 1'b1 : (take ? 1'b0 : valid_ff);
      if (accept) begin
         if (!started_ff) begin
            if (in_last) begin
               kind_in = KIND_LONE;
            end else begin
               kind_in    = KIND_FIRST;
               started_in = 1'b1;
               held_in    = in_phase;
            end
         end else begin
            if (in_last) begin
               kind_in    = KIND_END;
               started_in = 1'b0;
               held_in    = '0;
            end else begin
               kind_in = KIND_MID;
               held_in = in_phase;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         dr_ff   <= in_phase - held_ff;
         dl_ff   <= held_ff - in_phase;
      end
   end

   assign valid   = valid_ff;
   assign d_right = dr_ff;
   assign d_left  = dl_ff;
   assign kind    = kind_ff;

endmodule

`default_nettype wire

>>> sv/pcc_term.sv
// one coupling term: table lookup, gamma product, then sin - g with saturation
`default_nettype none

module pcc_term
   import pcc_pkg::*;
(
   input  wire logic         clock,
   input  wire pipe_ctl_type ctl,
   input  wire phase_type    d,
   input  wire gamma_type    gamma,
   output rate_type          term
);

   tab_idx_type              idx;
   trig_type                 sin_ff, cos_ff, sin2_ff;
   gterm_type                g_ff, g_in;
   logic [TRIG_W:0]          one_minus;
   logic [PROD_W-1:0]        prod;
   logic signed [WIDE_W-1:0] diff;

   assign idx = table_index(d);

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         sin_ff <= sine_lookup(idx);
         cos_ff <= sine_lookup(idx + tab_idx_type'(QUARTER));
      end
   end

   // 1 - cos stays within 0..2 in q12
   assign one_minus = ONE_Q12 - cos_ff;
   assign prod      = PROD_W'(gamma) * PROD_W'(one_minus[TRIG_W-1:0]);
   assign g_in      = G_W'((prod + HALF_Q12) >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         sin2_ff <= sin_ff;
         g_ff    <= g_in;
      end
   end

   assign diff = WIDE_W'(sin2_ff) - signed'({2'b00, g_ff});
   assign term = sat_rate(diff);

endmodule

`default_nettype wire

>>> sv/pcc_outq.sv
// rate sum, held left term and the two-entry result queue
`default_nettype none

module pcc_outq
   import pcc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire kind_type kind,
   input  wire rate_type term_right,
   input  wire rate_type term_left,
   output logic          take,
   output logic          out_valid,
   input  wire logic     out_ready,
   output rate_type      out_rate,
   output logic          out_last
);

   rate_type   q_rate_ff [2];
   logic       q_last_ff [2];
   rate_type   q_rate_in [2];
   logic       q_last_in [2];
   logic [1:0] count_ff, count_in, count_mid;
   rate_type   held_left_ff, held_left_in;
   logic [1:0] n_res;
   logic       pop;
   rate_type   sum, a_rate;
   logic       a_last;

   always_comb begin
      case (kind)
         KIND_FIRST: n_res = 2'd0;
         KIND_LONE:  n_res = 2'd1;
         KIND_MID:   n_res = 2'd1;
         KIND_END:   n_res = 2'd2;
         default:    n_res = 2'd0;
      endcase
   end

   // room is judged before the pop so ready never waits on the consumer
   assign take = in_valid && ((n_res == 2'd0) || (count_ff == 2'd0) ||
                              (count_ff == 2'd1 && n_res == 2'd1));
   assign pop  = out_valid && out_ready;

   assign sum    = sat_rate(WIDE_W'(held_left_ff) + WIDE_W'(term_right));
   assign a_rate = (kind == KIND_LONE) ? '0 : sum;
   assign a_last = (kind == KIND_LONE);

   always_comb begin
      q_rate_in[0] = pop ? q_rate_ff[1] : q_rate_ff[0];
      q_last_in[0] = pop ? q_last_ff[1] : q_last_ff[0];
      q_rate_in[1] = q_rate_ff[1];
      q_last_in[1] = q_last_ff[1];
      count_mid    = count_ff - {1'b0, pop};
      count_in     = count_mid;
      held_left_in = held_left_ff;
      if (take) begin
         case (kind)
            KIND_MID: held_left_in = term_left;
            default:  held_left_in = '0;
         endcase
         if (n_res != 2'd0) begin
            q_rate_in[count_mid[0]] = a_rate;
            q_last_in[count_mid[0]] = a_last;
            if (n_res == 2'd2) begin
               q_rate_in[1] = term_left;
               q_last_in[1] = 1'b1;
            end
            count_in = count_mid + n_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         held_left_ff <= '0;
      end else begin
         count_ff     <= count_in;
         held_left_ff <= held_left_in;
      end
   end

   always_ff @(posedge clock) begin
      q_rate_ff <= q_rate_in;
      q_last_ff <= q_last_in;
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_rate  = q_rate_ff[0];
   assign out_last  = q_last_ff[0];

endmodule

`default_nettype wire

>>> sv/phase_chain_coupling_rates.sv
// a request passes the input, lookup and product registers and the result queue
// throughput: one request per cycle unless the rsp side stalls; the chain's last
// request yields two results and holds the pipe while the result queue drains
// the rate is set by the two-entry result queue: one result per ready cycle
// synchronous active-high reset empties the pipe, drops any open chain, gamma = 4915
`default_nettype none

module phase_chain_coupling_rates
   import pcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [PHASE_W-1:0] req_tdata,   // [15:0] phase
   input  wire logic               req_tlast,   // last_element
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RATE_W-1:0]       rsp_tdata,   // [15:0] rate
   output logic                    rsp_tlast,   // last_rate
   input  wire logic               csr_wen,
   input  wire logic [GAMMA_W-1:0] csr_wdata    // gamma
);

   gamma_type    gamma_ff;
   pipe_ctl_type ctl;
   logic         v0, v1_ff, v1_in, v2_ff, v2_in;
   logic         free1, free2, take2;
   kind_type     kind0, kind1_ff, kind2_ff;
   phase_type    d_right, d_left;
   rate_type     term_right, term_left, rsp_rate;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
      end else if (csr_wen) begin
         gamma_ff <= csr_wdata;
      end
   end

   pcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_phase (PHASE_BITS'(req_tdata)),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .take     (ctl.load1),
      .valid    (v0),
      .d_right  (d_right),
      .d_left   (d_left),
      .kind     (kind0)
   );

   // bubbles collapse: a stage loads when the one after it is empty or moving on
   assign free2     = !v2_ff || take2;
   assign ctl.load2 = v1_ff && free2;
   assign free1     = !v1_ff || ctl.load2;
   assign ctl.load1 = v0 && free1;

   assign v1_in = ctl.load1 ? 1'b1 : (ctl.load2 ? 1'b0 : v1_ff);
   assign v2_in = ctl.load2 ? 1'b1 : (take2 ? 1'b0 : v2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         kind1_ff <= kind0;
      end
      if (ctl.load2) begin
         kind2_ff <= kind1_ff;
      end
   end

   pcc_term u_term_right (
      .clock (clock),
      .ctl   (ctl),
      .d     (d_right),
      .gamma (gamma_ff),
      .term  (term_right)
   );

   pcc_term u_term_left (
      .clock (clock),
      .ctl   (ctl),
      .d     (d_left),
      .gamma (gamma_ff),
      .term  (term_left)
   );

   pcc_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .kind       (kind2_ff),
      .term_right (term_right),
      .term_left  (term_left),
      .take       (take2),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rate   (rsp_rate),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_rate;

endmodule

`default_nettype wire
